// ===== rtl/grid_escape_multi_source_bfs_core_assert.svh =====
// Assertion macros shared by the RTL of the grid escape search core.
`ifndef GRID_ESCAPE_MULTI_SOURCE_BFS_CORE_ASSERT_SVH
`define GRID_ESCAPE_MULTI_SOURCE_BFS_CORE_ASSERT_SVH

// A condition that must hold at every clock edge outside of reset.
`define GEMSB_ASSERT_ALWAYS(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("assertion failed");

// An antecedent that must be followed in the same cycle by a consequent.
`define GEMSB_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

`endif

// ===== rtl/gemsb_pkg.sv =====
// ----------------------------------------------------------------------------
// gemsb_pkg
// Types, constants and helpers of the grid escape search core.
// ----------------------------------------------------------------------------
`default_nettype none

package gemsb_pkg;

  localparam int unsigned DIM_W        = 11;
  localparam int unsigned CFG_W        = 9;
  localparam int unsigned STEPS_W      = 17;
  localparam int unsigned MAX_ROWS_DEF = 256;
  localparam int unsigned MAX_COLS_DEF = 256;

  // Register indexes of the configuration port.
  localparam logic REG_NUM_ROWS = 1'b0;
  localparam logic REG_NUM_COLS = 1'b1;

  typedef enum logic [1:0] {
    CELL_WALL   = 2'd0,
    CELL_EMPTY  = 2'd1,
    CELL_FIRE   = 2'd2,
    CELL_PERSON = 2'd3
  } cell_e;

  typedef enum logic [1:0] {
    OUT_ESCAPED    = 2'd0,
    OUT_IMPOSSIBLE = 2'd1,
    OUT_NO_PERSON  = 2'd2
  } outcome_e;

  // Zero acts as one, values above the maximum act as the maximum.
  function automatic logic [DIM_W-1:0] eff_dim(input logic [CFG_W-1:0] v,
                                               input logic [DIM_W-1:0] maxv);
    logic [DIM_W-1:0] vx;
    vx = DIM_W'(v);
    if (vx == '0) return DIM_W'(1);
    if (vx > maxv) return maxv;
    return vx;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/grid_escape_multi_source_bfs_core.sv =====
// ----------------------------------------------------------------------------
// grid_escape_multi_source_bfs_core
// Loads a grid in raster order and runs a fire-first multi-source BFS to find
// the level at which the person reaches the border.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Beat contents
//  s_axis    in         tdata[1:0] cell_code, tlast last_cell
//  m_axis    out        tuser[1:0] outcome, tdata[16:0] escape_steps
//  cfg       in         index 0 num_rows, index 1 num_cols, data 9 bits
//
//  Loading takes one cell per cycle unless a register write holds it off. The
//  search dequeues each frontier entry (S_POP, S_ENTRY), then walks the four
//  neighbor directions: S_NBR reads the open map for a loaded neighbor in the
//  grid, S_CHK checks it and writes it back; S_POP steps the level at each
//  boundary. The open map and frontier queue are single synchronous memories.
//  Reset clears only control state; the memories need no clearing pass.
//  A finished result waits in the output register while the next grid loads.
`default_nettype none

module grid_escape_multi_source_bfs_core import gemsb_pkg::*; #(
  parameter int unsigned MAX_ROWS = MAX_ROWS_DEF,
  parameter int unsigned MAX_COLS = MAX_COLS_DEF
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  // cell stream
  input  wire logic             s_axis_tvalid,
  output logic                  s_axis_tready,
  input  wire logic [7:0]       s_axis_tdata,   // [1:0] cell_code
  input  wire logic             s_axis_tlast,   // last_cell
  // result stream
  output logic                  m_axis_tvalid,
  input  wire logic             m_axis_tready,
  output logic [23:0]           m_axis_tdata,   // [16:0] escape_steps
  output logic [1:0]            m_axis_tuser,   // [1:0] outcome
  // configuration writes
  input  wire logic             cfg_valid_i,
  output logic                  cfg_ready_o,
  input  wire logic             cfg_index_i,
  input  wire logic [CFG_W-1:0] cfg_data_i
);

`include "grid_escape_multi_source_bfs_core_assert.svh"

  // Cells are addressed as {row, col}, so the row and column of a queued
  // entry come back without any division.
  localparam int unsigned RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int unsigned CW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int unsigned AW = RW + CW;
  localparam int unsigned QW = AW + 1;
  localparam int unsigned QD = (1 << AW) + 1;
  localparam int unsigned EW = AW + 1;  // person tag on top of the address

  typedef enum logic [6:0] {
    S_LOAD  = 7'b0000001,
    S_PUSHP = 7'b0000010,
    S_POP   = 7'b0000100,
    S_ENTRY = 7'b0001000,
    S_NBR   = 7'b0010000,
    S_CHK   = 7'b0100000,
    S_DONE  = 7'b1000000
  } state_e;

  // Storage.
  logic          open_map [1 << AW];
  logic [EW-1:0] fifo_mem [QD];

  state_e           state_q, state_d;
  logic [CFG_W-1:0] num_rows_q, num_rows_d, num_cols_q, num_cols_d;
  logic [DIM_W-1:0] load_row_q, load_row_d, load_col_q, load_col_d;
  logic [RW-1:0]    prow_q, prow_d;
  logic [CW-1:0]    pcol_q, pcol_d;
  logic             pvalid_q, pvalid_d;
  logic [QW-1:0]    head_q, head_d, tail_q, tail_d, lvl_end_q, lvl_end_d;
  logic [QW-1:0]    level_q, level_d;
  logic [1:0]       dir_q, dir_d;
  logic [AW-1:0]    nb_addr_q, nb_addr_d;
  logic             out_valid_q, out_valid_d;
  logic [1:0]       outcome_q, outcome_d, res_code_q, res_code_d;
  logic [STEPS_W-1:0] steps_q, steps_d, res_steps_q, res_steps_d;

  // Memory ports.
  logic          om_we, om_wdata, om_re, om_rd_q;
  logic [AW-1:0] om_waddr, om_raddr;
  logic          ff_we, ff_re;
  logic [QW-1:0] ff_waddr, ff_raddr;
  logic [EW-1:0] ff_wdata, ff_rd_q;

  always_ff @(posedge clk_i) begin
    if (om_we) begin
      open_map[om_waddr] <= om_wdata;
    end
    if (om_re) begin
      om_rd_q <= open_map[om_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ff_we) begin
      fifo_mem[ff_waddr] <= ff_wdata;
    end
    if (ff_re) begin
      ff_rd_q <= fifo_mem[ff_raddr];
    end
  end

  // Effective grid size.
  logic [DIM_W-1:0] rows, cols;
  assign rows = eff_dim(num_rows_q, DIM_W'(MAX_ROWS));
  assign cols = eff_dim(num_cols_q, DIM_W'(MAX_COLS));

  // Fields of the entry just read from the frontier queue.
  logic             ent_tag;
  logic [DIM_W-1:0] ent_r, ent_c;
  assign ent_tag = ff_rd_q[EW-1];
  assign ent_r   = DIM_W'(ff_rd_q[AW-1:CW]);
  assign ent_c   = DIM_W'(ff_rd_q[CW-1:0]);

  logic on_border;
  assign on_border = (ent_r == '0) || (ent_c == '0) ||
                     (ent_r + DIM_W'(1) == rows) || (ent_c + DIM_W'(1) == cols);

  // Neighbor in the current direction: down, up, right, left.
  logic [DIM_W-1:0] nb_r, nb_c;
  logic             nb_in_grid, nb_loaded;
  always_comb begin
    nb_r       = ent_r;
    nb_c       = ent_c;
    nb_in_grid = 1'b0;
    case (dir_q)
      2'd0: begin
        nb_r       = ent_r + DIM_W'(1);
        nb_in_grid = nb_r < rows;
      end
      2'd1: begin
        nb_r       = ent_r - DIM_W'(1);
        nb_in_grid = ent_r != '0;
      end
      2'd2: begin
        nb_c       = ent_c + DIM_W'(1);
        nb_in_grid = nb_c < cols;
      end
      default: begin
        nb_c       = ent_c - DIM_W'(1);
        nb_in_grid = ent_c != '0;
      end
    endcase
    // Cells past the load position of this grid act as walls.
    nb_loaded = (nb_r < load_row_q) || ((nb_r == load_row_q) && (nb_c < load_col_q));
  end

  logic in_beat;
  logic [1:0] cell_code;
  // A register write takes the cycle, so the cell stream holds off for it.
  assign s_axis_tready = (state_q == S_LOAD) && !cfg_valid_i;
  assign cfg_ready_o   = (state_q == S_LOAD);
  assign in_beat       = s_axis_tvalid && s_axis_tready;
  assign cell_code     = s_axis_tdata[1:0];

  always_comb begin
    state_d     = state_q;
    num_rows_d  = num_rows_q;
    num_cols_d  = num_cols_q;
    load_row_d  = load_row_q;
    load_col_d  = load_col_q;
    prow_d      = prow_q;
    pcol_d      = pcol_q;
    pvalid_d    = pvalid_q;
    head_d      = head_q;
    tail_d      = tail_q;
    lvl_end_d   = lvl_end_q;
    level_d     = level_q;
    dir_d       = dir_q;
    nb_addr_d   = nb_addr_q;
    out_valid_d = out_valid_q;
    outcome_d   = outcome_q;
    steps_d     = steps_q;
    res_code_d  = res_code_q;
    res_steps_d = res_steps_q;
    om_we       = 1'b0;
    om_waddr    = nb_addr_q;
    om_wdata    = 1'b0;
    om_re       = 1'b0;
    om_raddr    = {nb_r[RW-1:0], nb_c[CW-1:0]};
    ff_we       = 1'b0;
    ff_waddr    = tail_q;
    ff_wdata    = {ent_tag, nb_addr_q};
    ff_re       = 1'b0;
    ff_raddr    = head_q;

    if (m_axis_tvalid && m_axis_tready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_LOAD: begin
        if (cfg_valid_i) begin
          case (cfg_index_i)
            REG_NUM_ROWS: num_rows_d = cfg_data_i;
            default:      num_cols_d = cfg_data_i;
          endcase
          load_row_d = '0;
          load_col_d = '0;
          tail_d     = '0;
          pvalid_d   = 1'b0;
        end else if (in_beat) begin
          if (load_row_q < rows) begin
            om_we    = 1'b1;
            om_waddr = {load_row_q[RW-1:0], load_col_q[CW-1:0]};
            om_wdata = (cell_code == CELL_EMPTY);
            if (cell_code == CELL_FIRE) begin
              ff_we    = 1'b1;
              ff_wdata = {1'b0, load_row_q[RW-1:0], load_col_q[CW-1:0]};
              tail_d   = tail_q + QW'(1);
            end else if (cell_code == CELL_PERSON) begin
              prow_d   = load_row_q[RW-1:0];
              pcol_d   = load_col_q[CW-1:0];
              pvalid_d = 1'b1;
            end
            if (load_col_q + DIM_W'(1) >= cols) begin
              load_col_d = '0;
              load_row_d = load_row_q + DIM_W'(1);
            end else begin
              load_col_d = load_col_q + DIM_W'(1);
            end
          end
          if (s_axis_tlast) begin
            if (pvalid_d) begin
              state_d = S_PUSHP;
            end else begin
              res_code_d  = OUT_NO_PERSON;
              res_steps_d = '0;
              state_d     = S_DONE;
            end
          end
        end
      end
      S_PUSHP: begin
        ff_we     = 1'b1;
        ff_wdata  = {1'b1, prow_q, pcol_q};
        tail_d    = tail_q + QW'(1);
        lvl_end_d = tail_q + QW'(1);
        head_d    = '0;
        level_d   = QW'(1);
        state_d   = S_POP;
      end
      S_POP: begin
        if (head_q == tail_q) begin
          res_code_d  = OUT_IMPOSSIBLE;
          res_steps_d = '0;
          state_d     = S_DONE;
        end else if (head_q == lvl_end_q) begin
          lvl_end_d = tail_q;
          level_d   = level_q + QW'(1);
        end else begin
          ff_re   = 1'b1;
          head_d  = head_q + QW'(1);
          state_d = S_ENTRY;
        end
      end
      S_ENTRY: begin
        if (ent_tag && on_border) begin
          res_code_d  = OUT_ESCAPED;
          res_steps_d = STEPS_W'(level_q);
          state_d     = S_DONE;
        end else begin
          dir_d   = 2'd0;
          state_d = S_NBR;
        end
      end
      S_NBR: begin
        if (nb_in_grid && nb_loaded) begin
          om_re     = 1'b1;
          nb_addr_d = {nb_r[RW-1:0], nb_c[CW-1:0]};
          state_d   = S_CHK;
        end else if (dir_q == 2'd3) begin
          state_d = S_POP;
        end else begin
          dir_d = dir_q + 2'd1;
        end
      end
      S_CHK: begin
        if (om_rd_q) begin
          om_we  = 1'b1;
          ff_we  = 1'b1;
          tail_d = tail_q + QW'(1);
        end
        if (dir_q == 2'd3) begin
          state_d = S_POP;
        end else begin
          dir_d   = dir_q + 2'd1;
          state_d = S_NBR;
        end
      end
      S_DONE: begin
        // Wait until the output register is free, then restart the loader.
        if (!out_valid_q || m_axis_tready) begin
          out_valid_d = 1'b1;
          outcome_d   = res_code_q;
          steps_d     = res_steps_q;
          load_row_d  = '0;
          load_col_d  = '0;
          head_d      = '0;
          tail_d      = '0;
          pvalid_d    = 1'b0;
          state_d     = S_LOAD;
        end
      end
      default: state_d = S_LOAD;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_LOAD;
      num_rows_q  <= CFG_W'(16);
      num_cols_q  <= CFG_W'(16);
      load_row_q  <= '0;
      load_col_q  <= '0;
      pvalid_q    <= 1'b0;
      head_q      <= '0;
      tail_q      <= '0;
      lvl_end_q   <= '0;
      level_q     <= '0;
      dir_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      num_rows_q  <= num_rows_d;
      num_cols_q  <= num_cols_d;
      load_row_q  <= load_row_d;
      load_col_q  <= load_col_d;
      pvalid_q    <= pvalid_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      lvl_end_q   <= lvl_end_d;
      level_q     <= level_d;
      dir_q       <= dir_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    prow_q      <= prow_d;
    pcol_q      <= pcol_d;
    nb_addr_q   <= nb_addr_d;
    outcome_q   <= outcome_d;
    steps_q     <= steps_d;
    res_code_q  <= res_code_d;
    res_steps_q <= res_steps_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = outcome_q;
  assign m_axis_tdata  = {{(24 - STEPS_W){1'b0}}, steps_q};

  // The queue head never passes the tail.
  `GEMSB_ASSERT_ALWAYS(a_head_le_tail, clk_i, rst_ni, head_q <= tail_q)
  // A new result only comes out of the done state.
  `GEMSB_ASSERT_IMPL(a_result_from_done, clk_i, rst_ni, $rose(out_valid_q), $past(state_q == S_DONE))
  // Only an escape carries a nonzero level.
  `GEMSB_ASSERT_IMPL(a_steps_zero, clk_i, rst_ni, out_valid_q && (outcome_q != OUT_ESCAPED), steps_q == '0)

endmodule

`default_nettype wire

// ===== bench/grid_escape_multi_source_bfs_core_test.sv =====
// ----------------------------------------------------------------------------
// grid_escape_multi_source_bfs_core_test
// Self-checking bench for the fire escape search core. Random and directed
// grids are streamed in under random idling on both sides, each search result
// is predicted by a behavioral copy of the search and compared field by field.
// ----------------------------------------------------------------------------
`default_nettype none

// Keeps a behavioral copy of the loader and the search, and the queue of
// search results that the core still owes.
class escape_scoreboard;
  localparam int unsigned GRID_COLS = 256;
  localparam int unsigned GRID_CELLS = 65536;
  localparam int unsigned PERSON_BIT = 32'h8000_0000;

  bit [8:0]    rows_reg;
  bit [8:0]    cols_reg;
  int unsigned load_row;
  int unsigned load_col;
  int unsigned loaded;
  int unsigned fire_count;
  int unsigned person_cell;
  bit          person_valid;
  bit          open_map[GRID_CELLS];
  int unsigned frontier[GRID_CELLS + 1];

  gemsb_pkg::outcome_e want_outcome[$];
  logic [16:0]         want_steps[$];
  int unsigned         mismatches;
  int unsigned         results;
  int unsigned         escaped_seen;
  int unsigned         blocked_seen;
  int unsigned         absent_seen;

  function new();
    rows_reg = 9'd16;
    cols_reg = 9'd16;
    restart_loader();
  endfunction

  // Zero acts as one and anything beyond the grid store acts as its size.
  function int unsigned used_dim(bit [8:0] v);
    if (v == 0) return 1;
    if (v > 256) return 256;
    return v;
  endfunction

  function void restart_loader();
    load_row = 0;
    load_col = 0;
    loaded = 0;
    fire_count = 0;
    person_cell = 0;
    person_valid = 0;
  endfunction

  function void write_reg(logic index, bit [8:0] value);
    if (index == gemsb_pkg::REG_NUM_ROWS) rows_reg = value;
    else cols_reg = value;
    restart_loader();
  endfunction

  function void add_result(gemsb_pkg::outcome_e o, int unsigned steps);
    want_outcome.insert(want_outcome.size(), o);
    want_steps.insert(want_steps.size(), 17'(steps));
    restart_loader();
  endfunction

  // Takes one accepted cell beat; on the final cell it runs the search.
  function void note_cell(gemsb_pkg::cell_e code, bit last);
    int unsigned rows;
    int unsigned cols;
    int unsigned idx;
    int unsigned head;
    int unsigned tail;
    int unsigned level_end;
    int unsigned level;
    int unsigned entry;
    int unsigned tag;
    int unsigned r;
    int unsigned c;
    int unsigned nidx;
    int nr;
    int nc;
    rows = used_dim(rows_reg);
    cols = used_dim(cols_reg);
    if (loaded < rows * cols && load_row < rows && load_col < cols) begin
      idx = load_row * GRID_COLS + load_col;
      open_map[idx] = (code == gemsb_pkg::CELL_EMPTY);
      if (code == gemsb_pkg::CELL_FIRE) begin
        frontier[fire_count] = idx;
        fire_count++;
      end else if (code == gemsb_pkg::CELL_PERSON) begin
        person_cell = idx;
        person_valid = 1;
      end
      load_col++;
      if (load_col >= cols) begin
        load_col = 0;
        load_row++;
      end
      loaded++;
    end
    if (!last) return;
    if (!person_valid) begin
      add_result(gemsb_pkg::OUT_NO_PERSON, 0);
      return;
    end
    // Fire sources sit ahead of the person, so fire claims cells first
    // within every level.
    tail = fire_count;
    frontier[tail] = person_cell | PERSON_BIT;
    tail++;
    head = 0;
    level = 1;
    while (head < tail) begin
      level_end = tail;
      while (head < level_end) begin
        entry = frontier[head];
        head++;
        idx = entry & ~PERSON_BIT;
        tag = entry & PERSON_BIT;
        r = idx / GRID_COLS;
        c = idx % GRID_COLS;
        if (tag != 0 && (r == 0 || c == 0 || r + 1 == rows || c + 1 == cols)) begin
          add_result(gemsb_pkg::OUT_ESCAPED, level);
          return;
        end
        for (int k = 0; k < 4; k++) begin
          nr = int'(r) + ((k == 0) ? 1 : (k == 1) ? -1 : 0);
          nc = int'(c) + ((k == 2) ? 1 : (k == 3) ? -1 : 0);
          if (nr < 0 || nc < 0 || nr >= int'(rows) || nc >= int'(cols)) continue;
          // Cells that never arrived behave as walls.
          if (nr * int'(cols) + nc >= int'(loaded)) continue;
          nidx = nr * GRID_COLS + nc;
          if (!open_map[nidx]) continue;
          open_map[nidx] = 0;
          if (tail < GRID_CELLS + 1) begin
            frontier[tail] = nidx | tag;
            tail++;
          end
        end
      end
      level++;
    end
    add_result(gemsb_pkg::OUT_IMPOSSIBLE, 0);
  endfunction

  function void check_result(logic [1:0] outcome, logic [16:0] steps);
    gemsb_pkg::outcome_e o;
    logic [16:0] s;
    results++;
    if (want_outcome.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("unexpected result beat: outcome %0d steps %0d", outcome, steps);
      return;
    end
    o = want_outcome.pop_front();
    s = want_steps.pop_front();
    case (o)
      gemsb_pkg::OUT_ESCAPED:    escaped_seen++;
      gemsb_pkg::OUT_IMPOSSIBLE: blocked_seen++;
      default:                   absent_seen++;
    endcase
    if (outcome !== o || steps !== s) begin
      mismatches++;
      if (mismatches <= 10)
        $display("result %0d mismatch: outcome exp %0d got %0d, steps exp %0d got %0d",
                 results, o, outcome, s, steps);
    end
  endfunction
endclass

module grid_escape_multi_source_bfs_core_test import gemsb_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT = 1_500_000;
  localparam int unsigned ITEM_TARGET = 1600;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             s_axis_tvalid = 1'b0;
  logic             s_axis_tready;
  logic [7:0]       s_axis_tdata = '0;   // [1:0] cell_code
  logic             s_axis_tlast = 1'b0; // last_cell
  logic             m_axis_tvalid;
  logic             m_axis_tready = 1'b0;
  logic [23:0]      m_axis_tdata;        // [16:0] escape_steps
  logic [1:0]       m_axis_tuser;        // [1:0] outcome
  logic             cfg_valid_i = 1'b0;
  logic             cfg_ready_o;
  logic             cfg_index_i = 1'b0;
  logic [CFG_W-1:0] cfg_data_i = '0;

  escape_scoreboard sb;
  int unsigned cycles;
  int unsigned cells_sent;
  int unsigned grids_sent;
  int unsigned cfg_writes;
  // The sender works in bursts; while calm is set it never pauses.
  int unsigned burst_left;
  bit          calm;

  grid_escape_multi_source_bfs_core u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Watchdog: a hung handshake or a search that never finishes ends here.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("Some tests failed");
      $finish;
    end
  end

  // The result side stalls on its own pattern: in a fixed rotation it is
  // always ready, ready on a coin toss per cycle, or under long back-pressure.
  always @(negedge clk_i) begin
    case ((cycles / 128) % 3)
      0:       m_axis_tready <= 1'b1;
      1:       m_axis_tready <= $urandom_range(0, 1);
      default: m_axis_tready <= ($urandom_range(0, 15) == 0);
    endcase
  end

  // Results are sampled at the rising edge, before the core updates them.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      sb.check_result(m_axis_tuser, m_axis_tdata[16:0]);
  end

  // Sends one cell beat. Valid stays high across back-to-back beats of a
  // burst and drops only for the gaps between bursts.
  task automatic send_cell(cell_e code, bit last);
    if (burst_left == 0) begin
      if (!calm) begin
        s_axis_tvalid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(negedge clk_i);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {6'b0, code};
    s_axis_tlast  <= last;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_cell(code, last);
    cells_sent++;
    if (last) grids_sent++;
    @(negedge clk_i);
  endtask

  // Waits until every expected result has come and the core has settled;
  // only then may a register be written.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    s_axis_tlast  <= 1'b0;
    while (sb.want_outcome.size() != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
  endtask

  task automatic write_cfg(logic index, logic [CFG_W-1:0] value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= index;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.write_reg(index, value);
    cfg_writes++;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Streams one random grid. Most grids are complete with one person; some
  // have no person or several, some stop early and some carry surplus cells.
  task automatic send_grid(int unsigned rows, int unsigned cols);
    int unsigned total;
    int unsigned count;
    int unsigned person_at;
    int unsigned style;
    int unsigned pick;
    cell_e code;
    total = rows * cols;
    style = $urandom_range(0, 19);
    count = total;
    if (total > 200 || style < 3) count = $urandom_range(1, (total > 40) ? 40 : total);
    else if (style < 5) count = total + $urandom_range(1, 4);
    person_at = $urandom_range(0, count - 1);
    for (int unsigned i = 0; i < count; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 25) code = CELL_WALL;
      else if (pick < 88) code = CELL_EMPTY;
      else if (pick < 96) code = CELL_FIRE;
      else code = (style == 19) ? CELL_PERSON : CELL_EMPTY;
      if (i == person_at && style != 18) code = CELL_PERSON;
      send_cell(code, i == count - 1);
    end
  endtask

  // Picks a register value: mostly small grids, sometimes the extremes and
  // out-of-range values that clamp.
  function automatic logic [CFG_W-1:0] pick_dim();
    case ($urandom_range(0, 19))
      0:       return 9'd0;
      1:       return 9'd256;
      2:       return 9'd511;
      3:       return 9'($urandom);
      4:       return 9'd1;
      default: return 9'($urandom_range(1, 10));
    endcase
  endfunction

  initial begin
    logic [CFG_W-1:0] rows_v;
    logic [CFG_W-1:0] cols_v;
    sb = new();
    cycles = 0;
    cells_sent = 0;
    grids_sent = 0;
    cfg_writes = 0;
    burst_left = 0;
    calm = 1'b0;
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed part at the reset size: a lone person on the top border, a
    // grid with fire but no person, and one with only a wall.
    send_cell(CELL_PERSON, 1'b1);
    send_cell(CELL_FIRE, 1'b1);
    send_cell(CELL_WALL, 1'b1);
    drain();
    write_cfg(REG_NUM_ROWS, 9'd3);
    write_cfg(REG_NUM_COLS, 9'd3);
    // A walled-in person cannot get out.
    for (int i = 0; i < 9; i++) send_cell((i == 4) ? CELL_PERSON : CELL_WALL, i == 8);
    // Fire in a corner races the person from the middle.
    send_cell(CELL_FIRE, 1'b0);   send_cell(CELL_EMPTY, 1'b0); send_cell(CELL_WALL, 1'b0);
    send_cell(CELL_EMPTY, 1'b0);  send_cell(CELL_PERSON, 1'b0); send_cell(CELL_EMPTY, 1'b0);
    send_cell(CELL_WALL, 1'b0);   send_cell(CELL_EMPTY, 1'b0); send_cell(CELL_WALL, 1'b1);
    drain();
    // Zero clamps to one: the second cell lands beyond the full grid and is
    // dropped, yet its last flag still starts the search.
    write_cfg(REG_NUM_ROWS, 9'd0);
    write_cfg(REG_NUM_COLS, 9'd0);
    send_cell(CELL_PERSON, 1'b0);
    send_cell(CELL_FIRE, 1'b1);
    // The sender holds off here until every result has come back.
    drain();

    // Random part in phases, each with its own size and idling mood.
    while (cells_sent < ITEM_TARGET || sb.results < 40) begin
      rows_v = pick_dim();
      cols_v = pick_dim();
      if ($urandom_range(0, 1)) begin
        write_cfg(REG_NUM_ROWS, rows_v);
        write_cfg(REG_NUM_COLS, cols_v);
      end else begin
        write_cfg(REG_NUM_COLS, cols_v);
        write_cfg(REG_NUM_ROWS, rows_v);
      end
      calm = ($urandom_range(0, 3) == 0);
      repeat ($urandom_range(1, 4))
        send_grid(sb.used_dim(rows_v), sb.used_dim(cols_v));
      drain();
    end

    repeat (50) @(negedge clk_i);
    $display("%0d cells in %0d grids over %0d register writes; %0d results checked",
             cells_sent, grids_sent, cfg_writes, sb.results);
    $display("outcomes: %0d escaped, %0d impossible, %0d without a person",
             sb.escaped_seen, sb.blocked_seen, sb.absent_seen);
    if (sb.mismatches == 0 && sb.want_outcome.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("%0d mismatches, %0d results still owed", sb.mismatches,
               sb.want_outcome.size());
      $display("Some tests failed");
    end
    $finish;
  end
endmodule

`default_nettype wire

// ===== files.f =====
+incdir+rtl
rtl/gemsb_pkg.sv
rtl/grid_escape_multi_source_bfs_core.sv
bench/grid_escape_multi_source_bfs_core_test.sv
